// File: rtl/biquad_pkg.sv
// ----------------------------------------------------------------------------
// biquad_pkg
// Shared constants and register codes for the direct form I biquad filter.
// ----------------------------------------------------------------------------
`default_nettype none

package biquad_pkg;

  // Default sizes: 24-bit samples, Q3.22 coefficients in 26 bits
  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_WIDTH_DEF     = 26;
  localparam int COEF_FRAC_BITS_DEF = 22;

  // Coefficient register file
  localparam int NUM_COEFS = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_idx_t;

  // Accumulator limit: wider sums wrap at this many bits
  localparam int ACC_MAX_W = 64;

endpackage

`default_nettype wire

// File: rtl/biquad_iir_filter.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter
// Second-order IIR filter, direct form I, one signed sample per transfer.
// y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, rounded half up and saturated.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in_     | sink      | in_tvalid/in_tready  | in_tdata: sample_in
//  out_    | source    | out_tvalid/out_tready| out_tdata: sample_out
//  cfg_    | sink      | cfg_valid/cfg_ready  | cfg_index, cfg_data: coefficient
//
//  One sample per cycle sustained while the output is ready; input register, then
//  five parallel multiplies, sum, round and saturate into the output register.
//  The output-history feedback closes inside that single stage.
//  Reset loads b0 = 1.0, other coefficients 0, and clears the history.
//  A coefficient write clears the history; cfg_ready is always high.
//  A stalled output holds the input register; input keeps flowing otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter #(
  parameter int SAMPLE_WIDTH   = biquad_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH     = biquad_pkg::COEF_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = biquad_pkg::COEF_FRAC_BITS_DEF,
  localparam int DATA_W        = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [DATA_W-1:0]                 in_tdata,   // [SW-1:0] sample_in
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [DATA_W-1:0]                      out_tdata,  // [SW-1:0] sample_out
  // coefficient writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [biquad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COEF_WIDTH-1:0]             cfg_data
);

  import biquad_pkg::*;

  localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int FULL_W  = PROD_W + 3;
  localparam int ACC_W   = (FULL_W > ACC_MAX_W) ? ACC_MAX_W : FULL_W;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX  =
    ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_MIN  = -SAT_MAX - ACC_W'(1);
  localparam logic [COEF_WIDTH-1:0]   B0_RESET = COEF_WIDTH'(1) << COEF_FRAC_BITS;

  // Coefficients
  logic signed [COEF_WIDTH-1:0]   coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;
  // Input register
  logic                           x_valid_r, x_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  // History
  logic signed [SAMPLE_WIDTH-1:0] x1_r, x2_r, y1_r, y2_r;
  // Output register
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] y_out_r;

  logic                           adv;
  logic                           in_xfer;
  logic                           cfg_xfer;
  logic                           cfg_hit;
  logic signed [PROD_W-1:0]       p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]        acc, acc_rnd, acc_sh;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  // Handshakes
  assign adv       = x_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !x_valid_r || adv;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // Decode a write to a known register
  always_comb begin
    unique case (cfg_index)
      COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2: cfg_hit = cfg_xfer;
      default:                                     cfg_hit = 1'b0;
    endcase
  end

  // Five products, summed exactly (wrapping at the accumulator limit)
  assign p_b0 = coef_b0_r * x_r;
  assign p_b1 = coef_b1_r * x1_r;
  assign p_b2 = coef_b2_r * x2_r;
  assign p_a1 = coef_a1_r * y1_r;
  assign p_a2 = coef_a2_r * y2_r;
  assign acc  = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2) - ACC_W'(p_a1) - ACC_W'(p_a2);

  // Round half up, floor shift, clamp to the sample range
  assign acc_rnd = acc + RND_HALF;
  assign acc_sh  = acc_rnd >>> COEF_FRAC_BITS;
  always_comb begin
    if (acc_sh > SAT_MAX) begin
      y_sat = SAMPLE_WIDTH'(SAT_MAX);
    end else if (acc_sh < SAT_MIN) begin
      y_sat = SAMPLE_WIDTH'(SAT_MIN);
    end else begin
      y_sat = SAMPLE_WIDTH'(acc_sh);
    end
  end

  // Valid flags: load on transfer in, drain on advance or transfer out
  always_comb begin
    x_valid_nxt = x_valid_r;
    if (in_xfer) begin
      x_valid_nxt = 1'b1;
    end else if (adv) begin
      x_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      x_valid_r   <= x_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r <= SAMPLE_WIDTH'(in_tdata);
    end
    if (adv) begin
      y_out_r <= y_sat;
    end
  end

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r <= B0_RESET;
      coef_b1_r <= '0;
      coef_b2_r <= '0;
      coef_a1_r <= '0;
      coef_a2_r <= '0;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        COEF_B0: coef_b0_r <= cfg_data;
        COEF_B1: coef_b1_r <= cfg_data;
        COEF_B2: coef_b2_r <= cfg_data;
        COEF_A1: coef_a1_r <= cfg_data;
        COEF_A2: coef_a2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // History: clear on reset or coefficient write, shift on advance
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (adv) begin
      x1_r <= x_r;
      x2_r <= x1_r;
      y1_r <= y_sat;
      y2_r <= y1_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'($unsigned(y_out_r));

  // Checks
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (x1_r == '0 && x2_r == '0 && y1_r == '0 && y2_r == '0))
    else $error("history not cleared after coefficient write");

  a_fb_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !cfg_hit) |=> (out_valid_r && y1_r == y_out_r))
    else $error("fed-back output differs from delivered output");

  a_x_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !cfg_hit) |=> (x1_r == $past(x_r) && x2_r == $past(x1_r)))
    else $error("input history shifted wrongly");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (x_valid_r && out_valid_r && !out_tready) |=> (x_valid_r && $stable(x_r)))
    else $error("input register lost during output stall");

endmodule

`default_nettype wire

// File: verif/biquad_iir_filter_tb.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter_tb
// Self-checking bench for the direct form I biquad. A bit-exact filter model
// inside the bench predicts every output sample from the accepted inputs and
// the coefficients written so far. A monitor compares each output transfer
// with the oldest prediction. Directed cases cover passthrough after reset,
// coefficient extremes, rounding and saturation feeding back into the history,
// and ignored register indexes. Random phases follow with fresh coefficient
// sets, random gaps on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import biquad_pkg::*;

  localparam int SW     = SAMPLE_WIDTH_DEF;
  localparam int CW     = COEF_WIDTH_DEF;
  localparam int FB     = COEF_FRAC_BITS_DEF;
  localparam int DATA_W = ((SW + 7) / 8) * 8;

  localparam longint SAT_HI = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< (SW - 1));
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [CW-1:0] COEF_MAX   = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COEF_MIN   = {1'b1, {(CW-1){1'b0}}};
  localparam int                   UNITY      = 1 << FB;

  // First index past the coefficient file; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_FIRST = CFG_IDX_W'(NUM_COEFS);
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LAST  = {CFG_IDX_W{1'b1}};

  localparam int HALF_PERIOD    = 6;
  localparam int SETTLE_CYCLES  = 4;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {COEFS_FULL, COEFS_GENTLE, COEFS_ALL_MAX, COEFS_ALL_MIN} coef_mix_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata;   // [SW-1:0] sample_in
  logic                 out_tvalid;
  logic                 out_tready;
  logic [DATA_W-1:0]    out_tdata;  // [SW-1:0] sample_out
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0]        cfg_data;

  // Filter model state: coefficients and the four history taps
  logic signed [CW-1:0] coef_q [NUM_COEFS];
  logic signed [SW-1:0] x_hist1, x_hist2, y_hist1, y_hist2;

  logic [DATA_W-1:0] pending_outputs[$];

  int  mismatches;
  int  samples_sent;
  int  outputs_checked;
  int  coef_writes;
  int  saturated_outputs;
  int  quiet_cycles;
  bit  tx_gaps_on;
  bit  rx_stalls_on;
  bit  long_hold_req;

  biquad_iir_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Filter model: exact sum, round half up, saturate, then update history
  function automatic logic signed [SW-1:0] filtered_sample(input logic signed [SW-1:0] x);
    longint acc;
    acc = longint'(coef_q[COEF_B0]) * longint'(x)
        + longint'(coef_q[COEF_B1]) * longint'(x_hist1)
        + longint'(coef_q[COEF_B2]) * longint'(x_hist2)
        - longint'(coef_q[COEF_A1]) * longint'(y_hist1)
        - longint'(coef_q[COEF_A2]) * longint'(y_hist2);
    acc = (acc + (longint'(1) <<< (FB - 1))) >>> FB;
    if (acc > SAT_HI) acc = SAT_HI;
    else if (acc < SAT_LO) acc = SAT_LO;
    x_hist2 = x_hist1;
    x_hist1 = x;
    y_hist2 = y_hist1;
    y_hist1 = acc[SW-1:0];
    return acc[SW-1:0];
  endfunction

  function automatic void clear_history();
    x_hist1 = '0;
    x_hist2 = '0;
    y_hist1 = '0;
    y_hist2 = '0;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_gap(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [SW-1:0] random_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return SAMPLE_MAX;
    if (r < 10) return SAMPLE_MIN;
    if (r < 40) return SW'(int'($urandom_range(0, 511)) - 256);
    return SW'($urandom);
  endfunction

  function automatic logic signed [CW-1:0] random_coef(input coef_mix_t mix,
                                                       input bit is_feedback);
    int span;
    span = is_feedback ? UNITY / 4 : UNITY;
    case (mix)
      COEFS_FULL:    return CW'($urandom);
      COEFS_GENTLE:  return CW'(int'($urandom_range(0, 2 * span)) - span);
      COEFS_ALL_MAX: return COEF_MAX;
      default:       return COEF_MIN;
    endcase
  endfunction

  // Offer one sample after an optional gap and predict its output
  task automatic send_sample(input logic signed [SW-1:0] s);
    int               gap;
    logic [DATA_W-1:0] word;
    gap = idle_gap(tx_gaps_on);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= DATA_W'($urandom);
    end
    word         = '0;
    word[SW-1:0] = s;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    word         = '0;
    word[SW-1:0] = filtered_sample(s);
    pending_outputs.push_back(word);
    samples_sent++;
  endtask

  // Drop the input and wait until every predicted output has been seen
  task automatic wait_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] value);
    wait_until_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_COEFS) begin
      coef_q[idx] = value;
      clear_history();
    end
    coef_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output ready: random bursts, or one long hold-off when requested
  initial begin : sink_ready
    int   n;
    logic level;
    forever begin
      @(negedge clk);
      n     = 1;
      level = 1'b1;
      if (long_hold_req) begin
        level         = 1'b0;
        n             = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (rx_stalls_on) begin
        case ($urandom_range(0, 19))
          0:             begin level = 1'b0; n = $urandom_range(10, 40); end
          1, 2, 3, 4, 5: begin level = 1'b0; n = $urandom_range(1, 3); end
          default:       n = $urandom_range(1, 8);
        endcase
      end
      out_tready <= level;
      repeat (n - 1) @(negedge clk);
    end
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected output %0d with nothing pending",
                   $signed(out_tdata[SW-1:0]));
      end else begin
        want = pending_outputs.pop_front();
        outputs_checked++;
        if (out_tdata[SW-1:0] == SAMPLE_MAX || out_tdata[SW-1:0] == SAMPLE_MIN)
          saturated_outputs++;
        if (out_tdata !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("output %0d: expected sample_out %0d, got %0d",
                     outputs_checked, $signed(want[SW-1:0]),
                     $signed(out_tdata[SW-1:0]));
        end
      end
    end
  end

  // End the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // After reset b0 is unity, so samples pass through unchanged
  task automatic test_reset_passthrough();
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SW'(1));
    send_sample(SW'(-1));
    send_sample(SW'(24'h5A5A5A));
  endtask

  // Largest gains of both signs drive the output into both rails
  task automatic test_coef_extremes();
    write_coef(COEF_B0, COEF_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SW'(1));
    write_coef(COEF_B0, COEF_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
  endtask

  // Half gain puts odd samples exactly on a rounding tie
  task automatic test_rounding();
    write_coef(COEF_B0, CW'(UNITY / 2));
    send_sample(SW'(1));
    send_sample(SW'(-1));
    send_sample(SW'(3));
    send_sample(SW'(-3));
  endtask

  // Leaky integrator that saturates; the clamped value must feed back
  task automatic test_feedback_saturation();
    write_coef(COEF_B0, CW'(UNITY));
    write_coef(COEF_B1, CW'(UNITY / 2));
    write_coef(COEF_B2, CW'(-(UNITY / 4)));
    write_coef(COEF_A1, CW'(-UNITY));
    write_coef(COEF_A2, CW'(UNITY / 8));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample('0);
    send_sample(SAMPLE_MIN);
    send_sample('0);
  endtask

  // Writes past the coefficient file leave coefficients and history alone
  task automatic test_unused_index();
    write_coef(IDX_UNUSED_FIRST, CW'($urandom));
    send_sample(SW'(1000));
    write_coef(IDX_UNUSED_LAST, CW'($urandom));
    send_sample(SW'(-1000));
  endtask

  // Random coefficient sets with random samples and idling on both sides
  task automatic test_random_phases();
    coef_mix_t mix;
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 5) mix = COEFS_ALL_MAX;
      else if (phase == 9) mix = COEFS_ALL_MIN;
      else if (phase % 3 == 1) mix = COEFS_FULL;
      else mix = COEFS_GENTLE;
      tx_gaps_on   = (phase != 0 && phase != 2);
      rx_stalls_on = (phase != 0 && phase != 1);
      for (int i = 0; i < NUM_COEFS; i++)
        write_coef(CFG_IDX_W'(i), random_coef(mix, i >= COEF_A1));
      repeat (90) send_sample(random_sample());
    end
  endtask

  // Hold the output off long enough to stall the input, then drain fully
  task automatic test_backpressure();
    tx_gaps_on    = 1'b0;
    long_hold_req = 1'b1;
    repeat (60) send_sample(random_sample());
    wait_until_drained();
    tx_gaps_on = 1'b1;
    repeat (30) send_sample(random_sample());
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    out_tready        = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    mismatches        = 0;
    samples_sent      = 0;
    outputs_checked   = 0;
    coef_writes       = 0;
    saturated_outputs = 0;
    quiet_cycles      = 0;
    tx_gaps_on        = 1'b0;
    rx_stalls_on      = 1'b0;
    long_hold_req     = 1'b0;
    coef_q[COEF_B0]   = CW'(UNITY);
    coef_q[COEF_B1]   = '0;
    coef_q[COEF_B2]   = '0;
    coef_q[COEF_A1]   = '0;
    coef_q[COEF_A2]   = '0;
    clear_history();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_passthrough();
    test_coef_extremes();
    test_rounding();
    test_feedback_saturation();
    test_unused_index();
    test_random_phases();
    test_backpressure();
    wait_until_drained();

    mismatches += pending_outputs.size();
    $display("covered %0d samples, %0d outputs checked (%0d at a rail), %0d register writes",
             samples_sent, outputs_checked, saturated_outputs, coef_writes);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
